>>> design/esc_pkg.sv
`default_nettype none

package esc_pkg;

  // Field widths
  localparam int unsigned EPOCH_W = 64;
  localparam int unsigned YEAR_W  = 40;

  // Seconds per day = 128 * 675: shift off 7 bits, then divide by 675
  localparam int unsigned SOD_SHIFT = 7;
  localparam int unsigned DIV1      = 675;
  localparam int unsigned DIV2      = 146097;  // days per 400 years
  localparam int unsigned DIV_BITS  = 8;       // quotient bits per divider stage

  // Internal widths
  localparam int unsigned U1_W    = 58;                 // biased floor(t / 128)
  localparam int unsigned U2_W    = 49;                 // biased day count from 1 March, year 0
  localparam int unsigned R1_W    = $clog2(DIV1);
  localparam int unsigned DOC_W   = $clog2(DIV2);       // day of 400-year cycle
  localparam int unsigned SOD_W   = R1_W + SOD_SHIFT;   // second of day
  localparam int unsigned CYC_W   = 33;                 // signed 400-year cycle count
  localparam int unsigned YACC_W  = 42;                 // year accumulator
  localparam int unsigned REM100_W = 16;
  localparam int unsigned REM4_W   = 11;
  localparam int unsigned REM1_W   = 9;
  localparam int unsigned D10_W    = 12;
  localparam int unsigned HREM_W   = 12;

  // Calendar constants
  localparam int unsigned MJD_EPOCH    = 40587;
  localparam int unsigned MJD_BIAS     = 678881;
  localparam int unsigned DAYS_100Y    = 36524;
  localparam int unsigned DAYS_4Y      = 1461;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned MONTH_TENTHS = 306;
  localparam int unsigned MONTH_COUNT  = 12;
  localparam int unsigned MONTH_WRAP   = 10;   // January and February belong to next year
  localparam int unsigned MONTH_SHIFT  = 2;
  localparam int unsigned DAY_ROUND    = 5;
  localparam int unsigned WEEK_OFFSET  = 3;
  localparam int unsigned WEEK_DAYS    = 7;
  localparam int unsigned CENTURY      = 100;
  localparam int unsigned SECS_HOUR    = 3600;
  localparam int unsigned SECS_MIN     = 60;
  localparam int unsigned HOURS_DAY    = 24;
  localparam int unsigned MAX_MDAY     = 31;

  // x / 10 == (x * 205) >> 11 for x below 1029
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

  // Biases that make both floor divisions work on non-negative values
  localparam logic [63:0] DIV1_BIAS_Q = (64'd1 << 56) / 64'(DIV1) + 64'd1;
  localparam logic [U1_W-1:0] DIV1_BIAS = U1_W'(DIV1_BIAS_Q * 64'(DIV1));
  localparam logic [63:0] DIV2_BIAS_Q = (64'd1 << 47) / 64'(DIV2) + 64'd1;
  localparam logic [U2_W-1:0] DIV2_OFFSET =
    U2_W'(DIV2_BIAS_Q * 64'(DIV2) + 64'(MJD_EPOCH) + 64'(MJD_BIAS) - DIV1_BIAS_Q);
  localparam logic [CYC_W-1:0] CYC_BIAS = CYC_W'(DIV2_BIAS_Q);

  // Pipeline depth
  localparam int unsigned D1_STAGES = (U1_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned D2_STAGES = (U2_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned POST_STAGES = 6;
  localparam int unsigned LATENCY = 1 + D1_STAGES + 1 + D2_STAGES + POST_STAGES;

endpackage

`default_nettype wire

>>> design/epoch_seconds_to_calendar.sv
`default_nettype none

// Channel   Ports                                   Transfer when
// -------   -------------------------------------   ----------------------------
// input     start, busy, in_epoch_seconds           start high, busy low
// result    out_valid, out_second ... out_year      out_valid high (one cycle)
//
// One timestamp enters per clock while busy is low. The pipeline depth is set
// by the two constant dividers (8 + 7 stages, 8 quotient bits each) plus
// input, rebase and six calendar stages.
// rst_n is synchronous and active low; busy is high only while rst_n is low.
// The result side has no back-pressure, so nothing in the pipeline ever stalls.

module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] in_epoch_seconds,
  output logic               out_valid,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_index,
  output logic [2:0]         out_weekday,
  output logic signed [39:0] out_year
);

  // ---------------------------------------------------------------------------
  // Input stage: floor(t / 128) by arithmetic shift, biased to stay positive
  // ---------------------------------------------------------------------------
  logic                             accept;
  logic                             s0_vld_r;
  logic [esc_pkg::U1_W-1:0]         s0_num_r;
  logic [esc_pkg::U1_W-1:0]         s0_num_nxt;
  logic [esc_pkg::SOD_SHIFT-1:0]    s0_frac_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  assign s0_num_nxt = {in_epoch_seconds[esc_pkg::EPOCH_W-1],
                       in_epoch_seconds[esc_pkg::EPOCH_W-1:esc_pkg::SOD_SHIFT]}
                      + esc_pkg::DIV1_BIAS;

  // ---------------------------------------------------------------------------
  // Divide by 675: quotient is the biased day number, remainder with the
  // shifted-off bits forms the second of the day
  // ---------------------------------------------------------------------------
  logic                             d1_vld;
  logic [esc_pkg::U1_W-1:0]         d1_quo;
  logic [esc_pkg::R1_W-1:0]         d1_rem;
  logic [esc_pkg::SOD_SHIFT-1:0]    d1_pay;

  esc_cdiv #(
    .W       (esc_pkg::U1_W),
    .DIVISOR (esc_pkg::DIV1),
    .BITS    (esc_pkg::DIV_BITS),
    .PW      (esc_pkg::SOD_SHIFT)
  ) u_div_day (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_num  (s0_num_r),
    .in_pay  (s0_frac_r),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_rem (d1_rem),
    .out_pay (d1_pay)
  );

  // ---------------------------------------------------------------------------
  // Rebase: swap the day bias for the one of the 400-year division and move
  // the origin to 1 March of year 0 (MJD shift folded into the same constant)
  // ---------------------------------------------------------------------------
  logic                             sm_vld_r;
  logic [esc_pkg::U2_W-1:0]         sm_num_r;
  logic [esc_pkg::U2_W-1:0]         sm_num_nxt;
  logic [esc_pkg::SOD_W-1:0]        sm_sod_r;

  assign sm_num_nxt = d1_quo[esc_pkg::U2_W-1:0] + esc_pkg::DIV2_OFFSET;

  // ---------------------------------------------------------------------------
  // Divide by 146097: quotient is the biased 400-year cycle, remainder the day
  // within the cycle; second of day rides along
  // ---------------------------------------------------------------------------
  logic                             d2_vld;
  logic [esc_pkg::U2_W-1:0]         d2_quo;
  logic [esc_pkg::DOC_W-1:0]        d2_rem;
  logic [esc_pkg::SOD_W-1:0]        d2_pay;

  esc_cdiv #(
    .W       (esc_pkg::U2_W),
    .DIVISOR (esc_pkg::DIV2),
    .BITS    (esc_pkg::DIV_BITS),
    .PW      (esc_pkg::SOD_W)
  ) u_div_era (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sm_vld_r),
    .in_num  (sm_num_r),
    .in_pay  (sm_sod_r),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_rem (d2_rem),
    .out_pay (d2_pay)
  );

  // ---------------------------------------------------------------------------
  // P1: cycle count, century within the cycle, weekday, hour
  // ---------------------------------------------------------------------------
  logic                             p1_vld_r;
  logic [esc_pkg::CYC_W-1:0]        p1_cyc_r,    p1_cyc_nxt;
  logic [1:0]                       p1_c100_r,   p1_c100_nxt;
  logic [esc_pkg::REM100_W-1:0]     p1_rem100_r, p1_rem100_nxt;
  logic [2:0]                       p1_wk_r,     p1_wk_nxt;
  logic [4:0]                       p1_hour_r,   p1_hour_nxt;
  logic [esc_pkg::HREM_W-1:0]       p1_hrem_r,   p1_hrem_nxt;

  always_comb begin : p1_logic
    logic [esc_pkg::DOC_W-1:0] base;
    logic [esc_pkg::DOC_W-1:0] wtmp;
    logic [5:0]                wsum;
    logic [3:0]                wfold;
    logic [esc_pkg::SOD_W-1:0] hrem;
    base  = '0;
    wtmp  = '0;
    wsum  = '0;
    wfold = '0;
    hrem  = '0;

    p1_cyc_nxt = {1'b0, d2_quo[esc_pkg::CYC_W-2:0]} - esc_pkg::CYC_BIAS;

    // The last day of a cycle falls into the fourth century as its leap day
    priority if (d2_rem >= esc_pkg::DOC_W'(3 * esc_pkg::DAYS_100Y)) begin
      p1_c100_nxt = 2'd3;
      base        = esc_pkg::DOC_W'(3 * esc_pkg::DAYS_100Y);
    end else if (d2_rem >= esc_pkg::DOC_W'(2 * esc_pkg::DAYS_100Y)) begin
      p1_c100_nxt = 2'd2;
      base        = esc_pkg::DOC_W'(2 * esc_pkg::DAYS_100Y);
    end else if (d2_rem >= esc_pkg::DOC_W'(esc_pkg::DAYS_100Y)) begin
      p1_c100_nxt = 2'd1;
      base        = esc_pkg::DOC_W'(esc_pkg::DAYS_100Y);
    end else begin
      p1_c100_nxt = 2'd0;
      base        = '0;
    end
    p1_rem100_nxt = esc_pkg::REM100_W'(d2_rem - base);

    // Weekday: 8 == 1 mod 7, so sum octal digits and fold
    wtmp = d2_rem + esc_pkg::DOC_W'(esc_pkg::WEEK_OFFSET);
    for (int k = 0; k < esc_pkg::DOC_W / 3; k++) begin
      wsum = wsum + 6'(wtmp[3*k +: 3]);
    end
    wfold = 4'(wsum[5:3]) + 4'(wsum[2:0]);
    p1_wk_nxt = (wfold >= 4'(esc_pkg::WEEK_DAYS)) ? 3'(wfold - 4'(esc_pkg::WEEK_DAYS))
                                                   : 3'(wfold);

    // Hour: restoring division by 3600, five quotient bits
    hrem        = d2_pay;
    p1_hour_nxt = '0;
    for (int k = 4; k >= 0; k--) begin
      if (hrem >= (esc_pkg::SOD_W'(esc_pkg::SECS_HOUR) << k)) begin
        hrem = hrem - (esc_pkg::SOD_W'(esc_pkg::SECS_HOUR) << k);
        p1_hour_nxt[k] = 1'b1;
      end
    end
    p1_hrem_nxt = esc_pkg::HREM_W'(hrem);
  end

  // ---------------------------------------------------------------------------
  // P2: four-year cycle within the century, minute and second, cycle years
  // ---------------------------------------------------------------------------
  logic                             p2_vld_r;
  logic [esc_pkg::YACC_W-1:0]       p2_yr_r,     p2_yr_nxt;
  logic [4:0]                       p2_c4_r,     p2_c4_nxt;
  logic [esc_pkg::REM4_W-1:0]       p2_rem4_r,   p2_rem4_nxt;
  logic [5:0]                       p2_min_r,    p2_min_nxt;
  logic [5:0]                       p2_sec_r,    p2_sec_nxt;
  logic [4:0]                       p2_hour_r;
  logic [2:0]                       p2_wk_r;

  always_comb begin : p2_logic
    logic [esc_pkg::REM100_W-1:0] r4;
    logic [esc_pkg::HREM_W-1:0]   rm;
    logic [esc_pkg::YACC_W-1:0]   cx;
    r4 = p1_rem100_r;
    rm = p1_hrem_r;
    cx = {{(esc_pkg::YACC_W - esc_pkg::CYC_W){p1_cyc_r[esc_pkg::CYC_W-1]}}, p1_cyc_r};

    p2_c4_nxt = '0;
    for (int k = 4; k >= 0; k--) begin
      if (r4 >= (esc_pkg::REM100_W'(esc_pkg::DAYS_4Y) << k)) begin
        r4 = r4 - (esc_pkg::REM100_W'(esc_pkg::DAYS_4Y) << k);
        p2_c4_nxt[k] = 1'b1;
      end
    end
    p2_rem4_nxt = esc_pkg::REM4_W'(r4);

    p2_min_nxt = '0;
    for (int k = 5; k >= 0; k--) begin
      if (rm >= (esc_pkg::HREM_W'(esc_pkg::SECS_MIN) << k)) begin
        rm = rm - (esc_pkg::HREM_W'(esc_pkg::SECS_MIN) << k);
        p2_min_nxt[k] = 1'b1;
      end
    end
    p2_sec_nxt = 6'(rm);

    // 400 * cycle + 100 * century
    p2_yr_nxt = (cx << 8) + (cx << 7) + (cx << 4)
                + esc_pkg::YACC_W'(9'(esc_pkg::CENTURY) * 9'(p1_c100_r));
  end

  // ---------------------------------------------------------------------------
  // P3: year within the four-year cycle; the leap day lands in the fourth year
  // ---------------------------------------------------------------------------
  logic                             p3_vld_r;
  logic [esc_pkg::YACC_W-1:0]       p3_yr_r,     p3_yr_nxt;
  logic [esc_pkg::REM1_W-1:0]       p3_rem1_r,   p3_rem1_nxt;
  logic [5:0]                       p3_min_r;
  logic [5:0]                       p3_sec_r;
  logic [4:0]                       p3_hour_r;
  logic [2:0]                       p3_wk_r;

  always_comb begin : p3_logic
    logic [1:0]                 c1;
    logic [esc_pkg::REM4_W-1:0] base;
    priority if (p2_rem4_r >= esc_pkg::REM4_W'(3 * esc_pkg::DAYS_YEAR)) begin
      c1   = 2'd3;
      base = esc_pkg::REM4_W'(3 * esc_pkg::DAYS_YEAR);
    end else if (p2_rem4_r >= esc_pkg::REM4_W'(2 * esc_pkg::DAYS_YEAR)) begin
      c1   = 2'd2;
      base = esc_pkg::REM4_W'(2 * esc_pkg::DAYS_YEAR);
    end else if (p2_rem4_r >= esc_pkg::REM4_W'(esc_pkg::DAYS_YEAR)) begin
      c1   = 2'd1;
      base = esc_pkg::REM4_W'(esc_pkg::DAYS_YEAR);
    end else begin
      c1   = 2'd0;
      base = '0;
    end
    p3_rem1_nxt = esc_pkg::REM1_W'(p2_rem4_r - base);
    // 4 * four-year count + year count is a plain concatenation
    p3_yr_nxt = p2_yr_r + esc_pkg::YACC_W'({p2_c4_r, c1});
  end

  // ---------------------------------------------------------------------------
  // P4: month counted from March via the 30.6-day fixed-point step
  // ---------------------------------------------------------------------------
  logic                             p4_vld_r;
  logic [esc_pkg::D10_W-1:0]        p4_d10_r,    p4_d10_nxt;
  logic [3:0]                       p4_mi_r,     p4_mi_nxt;
  logic [esc_pkg::YACC_W-1:0]       p4_yr_r;
  logic [5:0]                       p4_min_r;
  logic [5:0]                       p4_sec_r;
  logic [4:0]                       p4_hour_r;
  logic [2:0]                       p4_wk_r;

  always_comb begin : p4_logic
    p4_d10_nxt = (esc_pkg::D10_W'(p3_rem1_r) << 3) + (esc_pkg::D10_W'(p3_rem1_r) << 1)
                 + esc_pkg::D10_W'(esc_pkg::DAY_ROUND);
    p4_mi_nxt = '0;
    for (int k = 1; k < esc_pkg::MONTH_COUNT; k++) begin
      if (p4_d10_nxt >= esc_pkg::D10_W'(k * esc_pkg::MONTH_TENTHS)) begin
        p4_mi_nxt = 4'(k);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P5: tenths left in the month, January/February roll into the next year
  // ---------------------------------------------------------------------------
  logic                             p5_vld_r;
  logic [esc_pkg::REM1_W-1:0]       p5_rem_r,    p5_rem_nxt;
  logic [3:0]                       p5_month_r,  p5_month_nxt;
  logic [esc_pkg::YACC_W-1:0]       p5_yr_r,     p5_yr_nxt;
  logic [5:0]                       p5_min_r;
  logic [5:0]                       p5_sec_r;
  logic [4:0]                       p5_hour_r;
  logic [2:0]                       p5_wk_r;

  always_comb begin : p5_logic
    p5_rem_nxt = esc_pkg::REM1_W'(p4_d10_r
                 - esc_pkg::D10_W'(p4_mi_r) * esc_pkg::D10_W'(esc_pkg::MONTH_TENTHS));
    if (p4_mi_r >= 4'(esc_pkg::MONTH_WRAP)) begin
      p5_month_nxt = p4_mi_r - 4'(esc_pkg::MONTH_WRAP);
      p5_yr_nxt    = p4_yr_r + esc_pkg::YACC_W'(1);
    end else begin
      p5_month_nxt = p4_mi_r + 4'(esc_pkg::MONTH_SHIFT);
      p5_yr_nxt    = p4_yr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // P6 (output register): day of month = tenths / 10 + 1; skip year zero
  // ---------------------------------------------------------------------------
  logic                             p6_vld_r;
  logic [4:0]                       p6_mday_r,   p6_mday_nxt;
  logic [esc_pkg::YEAR_W-1:0]       p6_year_r,   p6_year_nxt;
  logic [3:0]                       p6_month_r;
  logic [5:0]                       p6_min_r;
  logic [5:0]                       p6_sec_r;
  logic [4:0]                       p6_hour_r;
  logic [2:0]                       p6_wk_r;

  always_comb begin : p6_logic
    logic [16:0]                prod;
    logic [esc_pkg::YACC_W-1:0] yr;
    prod = 17'(p5_rem_r) * 17'(esc_pkg::DIV10_MUL);
    p6_mday_nxt = 5'(prod >> esc_pkg::DIV10_SHIFT) + 5'd1;
    // Counted years at or below zero step down by one
    if (p5_yr_r[esc_pkg::YACC_W-1] || (p5_yr_r == '0)) begin
      yr = p5_yr_r - esc_pkg::YACC_W'(1);
    end else begin
      yr = p5_yr_r;
    end
    p6_year_nxt = yr[esc_pkg::YEAR_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Valid chain: the only state that reset clears
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      sm_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
      p6_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
      sm_vld_r <= d1_vld;
      p1_vld_r <= d2_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
      p6_vld_r <= p5_vld_r;
    end
  end

  // Payload registers advance every cycle; bubbles carry don't-care data
  always_ff @(posedge clk) begin
    s0_num_r    <= s0_num_nxt;
    s0_frac_r   <= in_epoch_seconds[esc_pkg::SOD_SHIFT-1:0];

    sm_num_r    <= sm_num_nxt;
    sm_sod_r    <= {d1_rem, d1_pay};

    p1_cyc_r    <= p1_cyc_nxt;
    p1_c100_r   <= p1_c100_nxt;
    p1_rem100_r <= p1_rem100_nxt;
    p1_wk_r     <= p1_wk_nxt;
    p1_hour_r   <= p1_hour_nxt;
    p1_hrem_r   <= p1_hrem_nxt;

    p2_yr_r     <= p2_yr_nxt;
    p2_c4_r     <= p2_c4_nxt;
    p2_rem4_r   <= p2_rem4_nxt;
    p2_min_r    <= p2_min_nxt;
    p2_sec_r    <= p2_sec_nxt;
    p2_hour_r   <= p1_hour_r;
    p2_wk_r     <= p1_wk_r;

    p3_yr_r     <= p3_yr_nxt;
    p3_rem1_r   <= p3_rem1_nxt;
    p3_min_r    <= p2_min_r;
    p3_sec_r    <= p2_sec_r;
    p3_hour_r   <= p2_hour_r;
    p3_wk_r     <= p2_wk_r;

    p4_d10_r    <= p4_d10_nxt;
    p4_mi_r     <= p4_mi_nxt;
    p4_yr_r     <= p3_yr_r;
    p4_min_r    <= p3_min_r;
    p4_sec_r    <= p3_sec_r;
    p4_hour_r   <= p3_hour_r;
    p4_wk_r     <= p3_wk_r;

    p5_rem_r    <= p5_rem_nxt;
    p5_month_r  <= p5_month_nxt;
    p5_yr_r     <= p5_yr_nxt;
    p5_min_r    <= p4_min_r;
    p5_sec_r    <= p4_sec_r;
    p5_hour_r   <= p4_hour_r;
    p5_wk_r     <= p4_wk_r;

    p6_mday_r   <= p6_mday_nxt;
    p6_year_r   <= p6_year_nxt;
    p6_month_r  <= p5_month_r;
    p6_min_r    <= p5_min_r;
    p6_sec_r    <= p5_sec_r;
    p6_hour_r   <= p5_hour_r;
    p6_wk_r     <= p5_wk_r;
  end

  // ---------------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------------
  assign out_valid        = p6_vld_r;
  assign out_second       = p6_sec_r;
  assign out_minute       = p6_min_r;
  assign out_hour         = p6_hour_r;
  assign out_day_of_month = p6_mday_r;
  assign out_month_index  = p6_month_r;
  assign out_weekday      = p6_wk_r;
  assign out_year         = signed'(p6_year_r);

endmodule

`default_nettype wire

>>> design/esc_cdiv.sv
`default_nettype none

// Pipelined unsigned division by a constant, BITS quotient bits per stage.
module esc_cdiv #(
  parameter int unsigned W       = 58,
  parameter int unsigned DIVISOR = 675,
  parameter int unsigned BITS    = 8,
  parameter int unsigned PW      = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [W-1:0]                  in_num,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_vld,
  output logic [W-1:0]                  out_quo,
  output logic [$clog2(DIVISOR)-1:0]    out_rem,
  output logic [PW-1:0]                 out_pay
);

  localparam int unsigned NS = (W + BITS - 1) / BITS;
  localparam int unsigned WP = NS * BITS;
  localparam int unsigned DW = $clog2(DIVISOR);
  localparam logic [DW:0] DIV_C = (DW + 1)'(DIVISOR);

  // Dividend bits shift out at the top while quotient bits shift in below
  logic [WP-1:0] x_r     [NS];
  logic [DW-1:0] rem_r   [NS];
  logic [PW-1:0] pay_r   [NS];
  logic [NS-1:0] vld_r;

  logic [WP-1:0] x_src   [NS];
  logic [DW-1:0] rem_src [NS];
  logic [PW-1:0] pay_src [NS];
  logic [WP-1:0] x_nxt   [NS];
  logic [DW-1:0] rem_nxt [NS];

  always_comb begin : stage_logic
    logic [DW-1:0]   rem_w;
    logic [DW:0]     trial;
    logic [BITS-1:0] qd;
    rem_w = '0;
    trial = '0;
    qd    = '0;
    x_src[0]   = WP'(in_num);
    rem_src[0] = '0;
    pay_src[0] = in_pay;
    for (int s = 1; s < NS; s++) begin
      x_src[s]   = x_r[s-1];
      rem_src[s] = rem_r[s-1];
      pay_src[s] = pay_r[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      rem_w = rem_src[s];
      qd    = '0;
      for (int k = 0; k < BITS; k++) begin
        trial = {rem_w, x_src[s][WP-1-k]};
        if (trial >= DIV_C) begin
          trial = trial - DIV_C;
          qd[BITS-1-k] = 1'b1;
        end
        rem_w = trial[DW-1:0];
      end
      x_nxt[s]   = {x_src[s][WP-BITS-1:0], qd};
      rem_nxt[s] = rem_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      x_r[s]   <= x_nxt[s];
      rem_r[s] <= rem_nxt[s];
      pay_r[s] <= pay_src[s];
    end
  end

  assign out_vld = vld_r[NS-1];
  assign out_quo = x_r[NS-1][W-1:0];
  assign out_rem = rem_r[NS-1];
  assign out_pay = pay_r[NS-1];

endmodule

`default_nettype wire

>>> design/esc_chk.sv
`default_nettype none

module esc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [5:0]         out_second,
  input logic [5:0]         out_minute,
  input logic [4:0]         out_hour,
  input logic [4:0]         out_day_of_month,
  input logic [3:0]         out_month_index,
  input logic [2:0]         out_weekday,
  input logic signed [39:0] out_year
);

  // Every transfer in produces its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(esc_pkg::LATENCY) out_valid)
    else $error("result missing after input transfer");

  // No result without a matching transfer in
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, esc_pkg::LATENCY))
    else $error("result without input transfer");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'(esc_pkg::SECS_MIN)) &&
                  (out_minute < 6'(esc_pkg::SECS_MIN)) &&
                  (out_hour < 5'(esc_pkg::HOURS_DAY)) &&
                  (out_day_of_month != 5'd0) &&
                  (out_day_of_month <= 5'(esc_pkg::MAX_MDAY)) &&
                  (out_month_index < 4'(esc_pkg::MONTH_COUNT)) &&
                  (out_weekday < 3'(esc_pkg::WEEK_DAYS)))
    else $error("calendar field out of range");

  a_no_year_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year != 40'sd0))
    else $error("year zero produced");

endmodule

bind epoch_seconds_to_calendar esc_chk u_esc_chk (.*);

`default_nettype wire
